FILE: src/rtc_pkg.sv
`timescale 1ns / 1ps

package rtc_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TOL_FRAC_BITS = 8;
    localparam int MAX_SAMPLES   = 65536;

    // Accumulator widths follow from the sample width and the largest set size.
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int SQIN_W   = 2 * SAMPLE_BITS - 1;
    localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int MAG_W    = SUM_W - 1;
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    // n*Q and S*S both stay at or below 2^62; the width must be odd so that the
    // root search starts on an even bit.
    localparam int WIDE_W   = 2 * MAG_W - 1;
    localparam int ROOT_W   = MAG_W;
    localparam int NUM_W    = ROOT_W + TOL_FRAC_BITS;
    localparam int DEN_W    = CNT_W + 6;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int TOL_W    = 17;
    localparam int DIFF_W   = 16;
    localparam int CMP_W    = DIFF_W + TOL_FRAC_BITS;

    localparam logic [TOL_W-1:0] TOL_MAX     = '1;
    localparam logic [6:0]       TOL_DIVISOR = 7'd100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic ACT_CAL = 1'b0;
    localparam logic ACT_CMP = 1'b1;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_TOL     = 1'b1;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] value_a;
        logic signed [SAMPLE_BITS-1:0] value_b;
        logic                          last_in_group;
        logic                          force_recalibrate;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic              within_tolerance;
        logic [DIFF_W-1:0] row_max_diff;
        logic [TOL_W-1:0]  tolerance_q;
        logic              calibrated;
    } out_item_t;

    typedef struct packed {
        logic take;
        logic smag_load;
        logic mul_ss;
        logic mul_lo;
        logic mul_hi;
        logic nq_sum;
        logic diff_load;
        logic sqrt_step;
        logic div_load;
        logic div_step;
        logic finish;
    } rtc_cmd_t;

    typedef struct packed {
        logic cal_close;
        logic sqrt_last;
        logic div_last;
    } rtc_status_t;

endpackage

FILE: src/rtc_outq.sv
`timescale 1ns / 1ps

module rtc_outq import rtc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_i,
    input  out_item_t data_i,
    output logic      full_o,
    output logic      valid_o,
    input  logic      ready_i,
    output out_item_t data_o
);

    out_item_t         ent_reg [QUEUE_DEPTH];
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic              pop;

    assign valid_o = (cnt_reg != '0);
    assign full_o  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop     = valid_o && ready_i;
    assign data_o  = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_i) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push_i && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push_i) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_i) begin
            ent_reg[wr_ptr_reg] <= data_i;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == QCNT_W'(QUEUE_DEPTH)) |-> !push_i)
        else $error("result pushed into a full queue");
`endif

endmodule

FILE: src/rtc_dp.sv
`timescale 1ns / 1ps

module rtc_dp import rtc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  in_item_t    in_data_i,
    input  rtc_cmd_t    cmd_i,
    output rtc_status_t sts_o,
    output logic        res_push_o,
    output out_item_t   res_o
);

    // Set and tolerance state.
    logic               has_tol_reg, has_tol_next;
    logic [TOL_W-1:0]   tol_reg, tol_next;
    logic               set_prog_reg, set_prog_next;
    logic               ignoring_reg, ignoring_next;
    logic [DIFF_W-1:0]  row_max_reg, row_max_next;

    // Accumulators.
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]    sq_sum_reg, sq_sum_next;
    logic [SQIN_W-1:0]  sq_reg;
    logic               sq_vld_reg;

    // Closing arithmetic.
    logic [MAG_W-1:0]     smag_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [WIDE_W-1:0]    ss_reg;
    logic [WIDE_W-1:0]    nq_reg;
    logic [WIDE_W-1:0]    x_reg;
    logic [WIDE_W-1:0]    res_reg;
    logic [WIDE_W-1:0]    bit_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                      first;
    logic                      ign_eff;
    logic                      is_cal, is_cmp;
    logic                      acc_en;
    logic [CNT_W-1:0]          cnt_base;
    logic [SUM_W-1:0]          sum_base;
    logic [SQ_W-1:0]           sq_sum_base;
    logic [SUM_W-1:0]          a_ext;
    logic signed [2*SAMPLE_BITS-1:0] sq_full;
    logic [SUM_W-1:0]          sum_neg;
    logic [SAMPLE_BITS:0]      d_raw;
    logic [SAMPLE_BITS:0]      d_abs;
    logic [DIFF_W-1:0]         diff;
    logic [DIFF_W-1:0]         rmax_cur;
    logic                      ok;
    logic [MUL_W-1:0]          mul_a, mul_b;
    logic [WIDE_W:0]           trial;
    logic                      trial_ok;
    logic [DEN_W:0]            rem_sh;
    logic                      div_ge;
    logic [DEN_W:0]            rem_sub;
    logic [TOL_W-1:0]          tol_new;

    assign first   = !set_prog_reg;
    assign ign_eff = first ? (has_tol_reg && !in_data_i.force_recalibrate) : ignoring_reg;
    assign is_cal  = cmd_i.take && (in_data_i.action == ACT_CAL);
    assign is_cmp  = cmd_i.take && (in_data_i.action == ACT_CMP);
    assign acc_en  = is_cal && !ign_eff && (first || (cnt_reg < CNT_W'(MAX_SAMPLES)));

    assign sts_o.cal_close = (in_data_i.action == ACT_CAL) && in_data_i.last_in_group
                             && !ign_eff;
    assign sts_o.sqrt_last = bit_reg[0];
    assign sts_o.div_last  = (div_cnt_reg == DIV_CNT_W'(1));

    // The first item of a set starts from cleared sums.
    assign cnt_base    = (is_cal && first) ? '0 : cnt_reg;
    assign sum_base    = (is_cal && first) ? '0 : sum_reg;
    assign sq_sum_base = (is_cal && first) ? '0 : sq_sum_reg;
    assign a_ext       = {{(SUM_W-SAMPLE_BITS){in_data_i.value_a[SAMPLE_BITS-1]}},
                          in_data_i.value_a};
    assign sq_full     = $signed(in_data_i.value_a) * $signed(in_data_i.value_a);
    assign sum_neg     = '0 - sum_reg;

    assign cnt_next    = acc_en ? cnt_base + 1'b1 : cnt_base;
    assign sum_next    = acc_en ? sum_base + a_ext : sum_base;
    // Squares land in the cycle after their transfer.
    assign sq_sum_next = sq_vld_reg ? sq_sum_base + SQ_W'(sq_reg) : sq_sum_base;

    // Row maximum and verdict.
    assign d_raw    = {in_data_i.value_a[SAMPLE_BITS-1], in_data_i.value_a}
                      - {in_data_i.value_b[SAMPLE_BITS-1], in_data_i.value_b};
    assign d_abs    = d_raw[SAMPLE_BITS] ? ('0 - d_raw) : d_raw;
    assign diff     = d_abs[DIFF_W-1:0];
    assign rmax_cur = (diff > row_max_reg) ? diff : row_max_reg;
    assign ok       = has_tol_reg
                      && ({rmax_cur, {TOL_FRAC_BITS{1'b0}}} < CMP_W'(tol_reg));

    // One shared multiplier covers S*S and the two halves of n*Q.
    always_comb begin
        if (cmd_i.mul_ss) begin
            mul_a = smag_reg;
            mul_b = smag_reg;
        end else if (cmd_i.mul_lo) begin
            mul_a = MUL_W'(cnt_reg);
            mul_b = sq_sum_reg[MUL_W-1:0];
        end else begin
            mul_a = MUL_W'(cnt_reg);
            mul_b = MUL_W'(sq_sum_reg[SQ_W-1:MUL_W]);
        end
    end

    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign trial_ok = ({1'b0, x_reg} >= trial);

    assign rem_sh  = {rem_reg, num_reg[NUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, den_reg});
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb begin
        if (den_reg == '0) begin
            tol_new = '0;
        end else if (|num_reg[NUM_W-1:TOL_W]) begin
            tol_new = TOL_MAX;
        end else begin
            tol_new = num_reg[TOL_W-1:0];
        end
    end

    always_comb begin
        has_tol_next  = has_tol_reg;
        tol_next      = tol_reg;
        set_prog_next = set_prog_reg;
        ignoring_next = ignoring_reg;
        row_max_next  = row_max_reg;
        if (is_cal) begin
            set_prog_next = !in_data_i.last_in_group;
            ignoring_next = in_data_i.last_in_group ? 1'b0 : ign_eff;
        end
        if (is_cmp) begin
            row_max_next = in_data_i.last_in_group ? '0 : rmax_cur;
        end
        if (cmd_i.finish) begin
            has_tol_next = 1'b1;
            tol_next     = tol_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_tol_reg  <= 1'b0;
            tol_reg      <= '0;
            set_prog_reg <= 1'b0;
            ignoring_reg <= 1'b0;
            row_max_reg  <= '0;
            sq_vld_reg   <= 1'b0;
        end else begin
            has_tol_reg  <= has_tol_next;
            tol_reg      <= tol_next;
            set_prog_reg <= set_prog_next;
            ignoring_reg <= ignoring_next;
            row_max_reg  <= row_max_next;
            sq_vld_reg   <= acc_en;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        sum_reg    <= sum_next;
        sq_sum_reg <= sq_sum_next;
        sq_reg     <= sq_full[SQIN_W-1:0];

        if (cmd_i.smag_load) begin
            smag_reg <= sum_reg[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_reg[MAG_W-1:0];
        end
        if (cmd_i.mul_ss || cmd_i.mul_lo || cmd_i.mul_hi) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd_i.mul_lo) begin
            ss_reg <= prod_reg[WIDE_W-1:0];
        end
        if (cmd_i.mul_hi) begin
            nq_reg <= prod_reg[WIDE_W-1:0];
        end
        if (cmd_i.nq_sum) begin
            nq_reg <= nq_reg + {prod_reg[WIDE_W-MUL_W-1:0], {MUL_W{1'b0}}};
        end

        // Digit-by-digit square root, one result bit per cycle.
        if (cmd_i.diff_load) begin
            x_reg   <= (nq_reg > ss_reg) ? nq_reg - ss_reg : '0;
            res_reg <= '0;
            bit_reg <= {1'b1, {(WIDE_W-1){1'b0}}};
        end else if (cmd_i.sqrt_step) begin
            if (trial_ok) begin
                x_reg   <= x_reg - trial[WIDE_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        // Restoring division; quotient bits shift in behind the dividend.
        if (cmd_i.div_load) begin
            num_reg     <= {res_reg[ROOT_W-1:0], {TOL_FRAC_BITS{1'b0}}};
            rem_reg     <= '0;
            den_reg     <= DEN_W'(cnt_reg) * DEN_W'(TOL_DIVISOR);
            div_cnt_reg <= DIV_CNT_W'(NUM_W);
        end else if (cmd_i.div_step) begin
            rem_reg     <= div_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            num_reg     <= {num_reg[NUM_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    assign res_push_o = cmd_i.finish || (is_cmp && in_data_i.last_in_group);

    always_comb begin
        if (cmd_i.finish) begin
            res_o.result_kind      = KIND_TOL;
            res_o.within_tolerance = 1'b0;
            res_o.row_max_diff     = '0;
            res_o.tolerance_q      = tol_new;
            res_o.calibrated       = 1'b1;
        end else begin
            res_o.result_kind      = KIND_VERDICT;
            res_o.within_tolerance = ok;
            res_o.row_max_diff     = rmax_cur;
            res_o.tolerance_q      = tol_reg;
            res_o.calibrated       = has_tol_reg;
        end
    end

`ifndef ASSERT_OFF
    a_tol_needs_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (tol_reg != '0) |-> has_tol_reg)
        else $error("tolerance held without the calibrated flag");
    a_finish_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.finish |=> has_tol_reg)
        else $error("calibrated flag not set after finishing");
    a_root_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.div_load |-> (bit_reg == '0))
        else $error("division started before the root search ended");
`endif

endmodule

FILE: src/rtc_ctrl.sv
`timescale 1ns / 1ps

module rtc_ctrl import rtc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid_i,
    output logic        s_ready_o,
    input  logic        q_full_i,
    input  rtc_status_t sts_i,
    output rtc_cmd_t    cmd_o
);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_PREP     = 11'b000_0000_0010,
        ST_MUL_SS   = 11'b000_0000_0100,
        ST_MUL_LO   = 11'b000_0000_1000,
        ST_MUL_HI   = 11'b000_0001_0000,
        ST_NQ_SUM   = 11'b000_0010_0000,
        ST_DIFF     = 11'b000_0100_0000,
        ST_SQRT     = 11'b000_1000_0000,
        ST_DIV_LOAD = 11'b001_0000_0000,
        ST_DIV      = 11'b010_0000_0000,
        ST_FINISH   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   take;

    assign s_ready_o = (state_reg == ST_IDLE) && !q_full_i;
    assign take      = s_valid_i && s_ready_o;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && sts_i.cal_close) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:     state_next = ST_MUL_SS;
            ST_MUL_SS:   state_next = ST_MUL_LO;
            ST_MUL_LO:   state_next = ST_MUL_HI;
            ST_MUL_HI:   state_next = ST_NQ_SUM;
            ST_NQ_SUM:   state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_SQRT;
            ST_SQRT: begin
                if (sts_i.sqrt_last) begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (sts_i.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign cmd_o.take      = take;
    assign cmd_o.smag_load = (state_reg == ST_PREP);
    assign cmd_o.mul_ss    = (state_reg == ST_MUL_SS);
    assign cmd_o.mul_lo    = (state_reg == ST_MUL_LO);
    assign cmd_o.mul_hi    = (state_reg == ST_MUL_HI);
    assign cmd_o.nq_sum    = (state_reg == ST_NQ_SUM);
    assign cmd_o.diff_load = (state_reg == ST_DIFF);
    assign cmd_o.sqrt_step = (state_reg == ST_SQRT);
    assign cmd_o.div_load  = (state_reg == ST_DIV_LOAD);
    assign cmd_o.div_step  = (state_reg == ST_DIV);
    assign cmd_o.finish    = (state_reg == ST_FINISH);

`ifndef ASSERT_OFF
    a_div_to_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && sts_i.div_last) |=> (state_reg == ST_FINISH))
        else $error("division end did not lead to the finish step");
    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> !q_full_i)
        else $error("tolerance ready but the result queue is full");
`endif

endmodule

FILE: src/regression_tolerance_checker_unit.sv
`timescale 1ns / 1ps
// Samples and compare elements are taken one per cycle while the queue has
// room; a row verdict enters the result queue with the row's last transfer.
// The last sample of an unskipped calibration set starts a closing sequence
// (multiplies, a 32-step root, a 40-step divide) during which input stalls.
// Results pass through a two-entry queue, so input flows while one waits.
// Synchronous active-low reset clears the tolerance, set state and queue.

module regression_tolerance_checker_unit import rtc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    rtc_cmd_t    cmd;
    rtc_status_t sts;
    logic        res_push;
    out_item_t   res;
    logic        q_full;

    rtc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_valid),
        .s_ready_o (s_ready),
        .q_full_i  (q_full),
        .sts_i     (sts),
        .cmd_o     (cmd)
    );

    rtc_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_data_i  (s_data),
        .cmd_i      (cmd),
        .sts_o      (sts),
        .res_push_o (res_push),
        .res_o      (res)
    );

    rtc_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (res_push),
        .data_i  (res),
        .full_o  (q_full),
        .valid_o (m_valid),
        .ready_i (m_ready),
        .data_o  (m_data)
    );

endmodule

FILE: tb/regression_tolerance_checker_unit_tb.sv
`timescale 1ns / 1ps

module regression_tolerance_checker_unit_tb import rtc_pkg::*; ();

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        in_item_t  stim;
        bit        fixed;
        out_item_t want;
    } plan_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Predicted state of the checker.
    bit                   tol_ready    = 1'b0;
    logic [TOL_W-1:0]     tol_q        = '0;
    longint unsigned      n_samples    = 0;
    longint               sample_total = 0;
    longint unsigned      square_total = 0;
    bit                   set_open     = 1'b0;
    bit                   set_skipped  = 1'b0;
    logic [DIFF_W-1:0]    row_peak     = '0;

    out_item_t   awaited_results[$];
    plan_row_t   directed_plan[$];
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request  = 0;

    regression_tolerance_checker_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic in_item_t make_item(logic act, int a, int b, logic last, logic recal);
        in_item_t it;
        it.action            = act;
        it.value_a           = a[SAMPLE_BITS-1:0];
        it.value_b           = b[SAMPLE_BITS-1:0];
        it.last_in_group     = last;
        it.force_recalibrate = recal;
        return it;
    endfunction

    // Root built one bit at a time from the top; the root never exceeds 2^31.
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x) begin
                root = cand;
            end
        end
        return root;
    endfunction

    function automatic logic [TOL_W-1:0] spread_tolerance();
        longint unsigned mag_sum;
        longint unsigned nq;
        longint unsigned ss;
        longint unsigned dev;
        longint unsigned t;
        mag_sum = (sample_total < 0) ? -sample_total : sample_total;
        nq  = n_samples * square_total;
        ss  = mag_sum * mag_sum;
        dev = (nq > ss) ? nq - ss : 0;
        if (n_samples == 0) begin
            return '0;
        end
        t = (int_sqrt(dev) << TOL_FRAC_BITS) / (100 * n_samples);
        return (t > TOL_MAX) ? TOL_MAX : t[TOL_W-1:0];
    endfunction

    task automatic predict_outcome(input in_item_t it, output bit emits, output out_item_t res);
        longint va;
        longint vb;
        longint gap;
        bit     ok;
        emits = 1'b0;
        res   = '0;
        va = longint'($signed(it.value_a));
        vb = longint'($signed(it.value_b));
        if (it.action == ACT_CAL) begin
            if (!set_open) begin
                set_open     = 1'b1;
                set_skipped  = tol_ready && !it.force_recalibrate;
                n_samples    = 0;
                sample_total = 0;
                square_total = 0;
            end
            // Samples past the set capacity are dropped, but the last mark still counts.
            if (!set_skipped && n_samples < MAX_SAMPLES) begin
                n_samples++;
                sample_total += va;
                square_total += longint'(va * va);
            end
            if (it.last_in_group) begin
                set_open = 1'b0;
                if (set_skipped) begin
                    set_skipped = 1'b0;
                end else begin
                    tol_q     = spread_tolerance();
                    tol_ready = 1'b1;
                    emits     = 1'b1;
                    res       = '{KIND_TOL, 1'b0, '0, tol_q, 1'b1};
                end
            end
        end else begin
            gap = va - vb;
            if (gap < 0) begin
                gap = -gap;
            end
            if (gap[DIFF_W-1:0] > row_peak) begin
                row_peak = gap[DIFF_W-1:0];
            end
            if (it.last_in_group) begin
                ok = tol_ready &&
                     ((longint'(row_peak) << TOL_FRAC_BITS) < longint'(tol_q));
                emits    = 1'b1;
                res      = '{KIND_VERDICT, ok, row_peak, tol_q, tol_ready};
                row_peak = '0;
            end
        end
    endtask

    function automatic in_item_t random_item();
        int centre;
        int a;
        int b;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 45) begin
            if (pick < 45) begin
                a = int'($urandom_range(65535));
            end else if (pick < 85) begin
                centre = int'($urandom_range(65535));
                a = centre + int'($urandom_range(4000)) - 2000;
            end else begin
                a = $urandom_range(1) ? 32'h7FFF : 32'h8000;
            end
            return make_item(ACT_CAL, a, int'($urandom_range(65535)),
                             $urandom_range(99) < 25, $urandom_range(99) < 40);
        end
        a = int'($urandom_range(65535));
        if (pick < 70) begin
            b = a + int'($urandom_range(800)) - 400;
        end else begin
            b = int'($urandom_range(65535));
        end
        return make_item(ACT_CMP, a, b, $urandom_range(99) < 35, $urandom_range(1));
    endfunction

    function automatic void report_mismatch(string what, longint got, longint want);
        $display("mismatch in %s at cycle %0d: got %0h, expected %0h",
                 what, cycle_count, got, want);
        error_count++;
    endfunction

    // Called on a falling edge; returns on the falling edge after the transfer.
    task automatic offer(input in_item_t it, input bit fixed, input out_item_t want);
        bit        emits;
        out_item_t res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_outcome(it, emits, res);
        if (emits) begin
            awaited_results.push_back(fixed ? want : res);
        end
        @(negedge aclk);
    endtask

    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left == 0 && hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", longint'(m_data), 0);
            end else begin
                want = awaited_results.pop_front();
                if (m_data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", m_data.result_kind, want.result_kind);
                if (m_data.within_tolerance !== want.within_tolerance)
                    report_mismatch("within_tolerance", m_data.within_tolerance,
                                    want.within_tolerance);
                if (m_data.row_max_diff !== want.row_max_diff)
                    report_mismatch("row_max_diff", m_data.row_max_diff, want.row_max_diff);
                if (m_data.tolerance_q !== want.tolerance_q)
                    report_mismatch("tolerance_q", m_data.tolerance_q, want.tolerance_q);
                if (m_data.calibrated !== want.calibrated)
                    report_mismatch("calibrated", m_data.calibrated, want.calibrated);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        plan_row_t row;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;

        // Rows with a typed result: extremes before calibration and zero-spread sets.
        directed_plan.push_back('{make_item(ACT_CMP, 32767, -32768, 1, 0), 1'b1,
                                  out_item_t'{KIND_VERDICT, 1'b0, 16'hFFFF, 17'd0, 1'b0}});
        directed_plan.push_back('{make_item(ACT_CMP, -32768, 32767, 1, 1), 1'b1,
                                  out_item_t'{KIND_VERDICT, 1'b0, 16'hFFFF, 17'd0, 1'b0}});
        directed_plan.push_back('{make_item(ACT_CMP, 0, 0, 1, 0), 1'b1,
                                  out_item_t'{KIND_VERDICT, 1'b0, 16'h0, 17'd0, 1'b0}});
        directed_plan.push_back('{make_item(ACT_CAL, 32767, 0, 1, 0), 1'b1,
                                  out_item_t'{KIND_TOL, 1'b0, 16'h0, 17'd0, 1'b1}});
        // A tolerance exists now, so a set without the recalibrate flag is skipped.
        directed_plan.push_back('{make_item(ACT_CAL, 100, 0, 0, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, -100, 0, 1, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, 0, 0, 1, 0), 1'b1,
                                  out_item_t'{KIND_VERDICT, 1'b0, 16'h0, 17'd0, 1'b1}});
        // Forced recalibration with a compare element interleaved inside the set.
        directed_plan.push_back('{make_item(ACT_CAL, -32768, 0, 0, 1), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, 7, -7, 0, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, 32767, -1, 1, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, 3, 5, 0, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, 300, 0, 1, 0), 1'b0, '0});
        // Either side of the tolerance boundary.
        directed_plan.push_back('{make_item(ACT_CMP, 0, 328, 1, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, 327, 0, 1, 0), 1'b0, '0});
        // The recalibrate flag is only honoured on the first sample of a set.
        directed_plan.push_back('{make_item(ACT_CAL, 5, 0, 0, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, 9, 0, 1, 1), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, -1, 0, 1, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, 0, 0, 0, 1), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, 0, 0, 1, 0), 1'b1,
                                  out_item_t'{KIND_TOL, 1'b0, 16'h0, 17'd0, 1'b1}});
        directed_plan.push_back('{make_item(ACT_CMP, 0, 0, 1, 0), 1'b1,
                                  out_item_t'{KIND_VERDICT, 1'b0, 16'h0, 17'd0, 1'b1}});
        directed_plan.push_back('{make_item(ACT_CAL, 1000, 0, 0, 1), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, -1000, 0, 0, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CAL, 0, 0, 1, 0), 1'b0, '0});
        directed_plan.push_back('{make_item(ACT_CMP, -32768, -32768, 1, 0), 1'b0, '0});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            offer(row.stim, row.fixed, row.want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int k = 0; k < 110; k++) begin
                offer(random_item(), 1'b0, '0);
            end
        end

        // Long receiver hold-off while transfers keep coming, so the result queue fills.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 400;
        for (int k = 0; k < 60; k++) begin
            offer(random_item(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
